FILE: src/jsu_pkg.sv
package jsu_pkg;

  // Longest string length the byte count tracks
  localparam int MAX_LEN = 4096;
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MASK = '1;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    (MAX_LEN > 8191) ? COUNT_MASK : COUNT_W'(MAX_LEN);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Escape decoder state
  typedef enum logic [2:0] {
    ESC_NORMAL = 3'd0,
    ESC_BSLASH = 3'd1,
    ESC_HEX1   = 3'd2,
    ESC_HEX2   = 3'd3,
    ESC_HEX3   = 3'd4,
    ESC_HEX4   = 3'd5
  } esc_t;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0C;
  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;
  localparam logic [7:0] TAB_CODE = 8'h09;

  // UTF-8 encoding limits and marks
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] CONT = 8'h80;

  // Results caused by one input word
  typedef struct packed {
    logic [1:0]         n;
    logic [2:0][7:0]    bytes;
    kind_t              kind;
    logic [COUNT_W-1:0] count;
  } run_t;

endpackage

FILE: src/jsu_if.sv
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source(output valid, in_byte, end_mark, input ready);
  modport sink(input valid, in_byte, end_mark, output ready);
endinterface

interface jsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  jsu_pkg::kind_t              kind;
  logic [jsu_pkg::COUNT_W-1:0] out_count;
  logic                        run_last;

  modport source(output valid, out_byte, kind, out_count, run_last, input ready);
  modport sink(input valid, out_byte, kind, out_count, run_last, output ready);
endinterface

FILE: src/jsu_decode.sv
module jsu_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          end_mark,
  output jsu_pkg::run_t run
);

  jsu_pkg::esc_t escape_mode, escape_mode_next;
  logic [15:0] hex_value, hex_value_next;
  logic error_seen, error_seen_next;
  logic [jsu_pkg::COUNT_W-1:0] byte_count, byte_count_next;

  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] code;
  logic [jsu_pkg::COUNT_W:0] count_sum;

  // Hex digit decode, either case
  always_comb begin
    digit = 4'd0;
    digit_ok = 1'b1;
    if (in_byte inside {[8'h30:8'h39]}) begin
      digit = in_byte[3:0];
    end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      digit = in_byte[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign code = {hex_value[11:0], digit};

  // Escape decode and UTF-8 encode
  always_comb begin
    escape_mode_next = escape_mode;
    hex_value_next = hex_value;
    error_seen_next = error_seen;
    run = '0;
    run.kind = jsu_pkg::KIND_DATA;

    if (end_mark) begin
      run.n = 2'd1;
      run.kind = (error_seen || escape_mode != jsu_pkg::ESC_NORMAL) ?
                 jsu_pkg::KIND_ERR : jsu_pkg::KIND_OK;
      run.count = byte_count;
      escape_mode_next = jsu_pkg::ESC_NORMAL;
      hex_value_next = 16'h0000;
      error_seen_next = 1'b0;
    end else if (!error_seen) begin
      case (escape_mode)
        jsu_pkg::ESC_NORMAL: begin
          if (in_byte == jsu_pkg::CH_BSLASH) begin
            escape_mode_next = jsu_pkg::ESC_BSLASH;
          end else begin
            run.n = 2'd1;
            run.bytes[0] = in_byte;
          end
        end
        jsu_pkg::ESC_BSLASH: begin
          escape_mode_next = jsu_pkg::ESC_NORMAL;
          run.n = 2'd1;
          case (in_byte)
            jsu_pkg::CH_QUOTE:  run.bytes[0] = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: run.bytes[0] = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  run.bytes[0] = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:      run.bytes[0] = jsu_pkg::BS_CODE;
            jsu_pkg::CH_F:      run.bytes[0] = jsu_pkg::FF_CODE;
            jsu_pkg::CH_N:      run.bytes[0] = jsu_pkg::LF_CODE;
            jsu_pkg::CH_R:      run.bytes[0] = jsu_pkg::CR_CODE;
            jsu_pkg::CH_T:      run.bytes[0] = jsu_pkg::TAB_CODE;
            jsu_pkg::CH_U: begin
              run.n = 2'd0;
              escape_mode_next = jsu_pkg::ESC_HEX1;
              hex_value_next = 16'h0000;
            end
            default: begin
              run.n = 2'd0;
              error_seen_next = 1'b1;
            end
          endcase
        end
        jsu_pkg::ESC_HEX1, jsu_pkg::ESC_HEX2, jsu_pkg::ESC_HEX3,
        jsu_pkg::ESC_HEX4: begin
          if (!digit_ok) begin
            error_seen_next = 1'b1;
            escape_mode_next = jsu_pkg::ESC_NORMAL;
            hex_value_next = 16'h0000;
          end else if (escape_mode != jsu_pkg::ESC_HEX4) begin
            hex_value_next = code;
            escape_mode_next = jsu_pkg::esc_t'(escape_mode + 3'd1);
          end else begin
            // Last digit: encode the code unit
            escape_mode_next = jsu_pkg::ESC_NORMAL;
            hex_value_next = 16'h0000;
            if (code <= jsu_pkg::ONE_BYTE_MAX) begin
              run.n = 2'd1;
              run.bytes[0] = code[7:0];
            end else if (code <= jsu_pkg::TWO_BYTE_MAX) begin
              run.n = 2'd2;
              run.bytes[0] = jsu_pkg::LEAD2 | {3'b000, code[10:6]};
              run.bytes[1] = jsu_pkg::CONT | {2'b00, code[5:0]};
            end else begin
              run.n = 2'd3;
              run.bytes[0] = jsu_pkg::LEAD3 | {4'h0, code[15:12]};
              run.bytes[1] = jsu_pkg::CONT | {2'b00, code[11:6]};
              run.bytes[2] = jsu_pkg::CONT | {2'b00, code[5:0]};
            end
          end
        end
        default: begin
          escape_mode_next = jsu_pkg::ESC_NORMAL;
        end
      endcase
    end
  end

  // Saturating count of data bytes
  assign count_sum = {1'b0, byte_count} + {{(jsu_pkg::COUNT_W-1){1'b0}}, run.n};

  always_comb begin
    if (end_mark) begin
      byte_count_next = '0;
    end else if (count_sum > {1'b0, jsu_pkg::COUNT_LIMIT}) begin
      byte_count_next = jsu_pkg::COUNT_LIMIT;
    end else begin
      byte_count_next = count_sum[jsu_pkg::COUNT_W-1:0];
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= jsu_pkg::ESC_NORMAL;
      hex_value <= 16'h0000;
      error_seen <= 1'b0;
      byte_count <= '0;
    end else if (accept) begin
      escape_mode <= escape_mode_next;
      hex_value <= hex_value_next;
      error_seen <= error_seen_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

FILE: src/jsu_emit.sv
module jsu_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::run_t    run,
  output logic             can_take,
  jsu_out_if.source        dout
);

  logic [1:0]                  rem;
  logic [2:0][7:0]             bytes;
  jsu_pkg::kind_t              kind;
  logic [jsu_pkg::COUNT_W-1:0] count;
  logic                        pop;

  assign pop = dout.valid && dout.ready;

  // Free next cycle when empty or the last word is leaving
  assign can_take = (rem == 2'd0) || (rem == 2'd1 && dout.ready);

  // Remaining word count
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= run.n;
    end else if (pop) begin
      rem <= rem - 2'd1;
    end
  end

  // Result payload, shifted down one byte per word sent
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= run.bytes;
      kind <= run.kind;
      count <= run.count;
    end else if (pop) begin
      bytes <= {8'h00, bytes[2], bytes[1]};
    end
  end

  assign dout.valid = (rem != 2'd0);
  assign dout.out_byte = bytes[0];
  assign dout.kind = kind;
  assign dout.out_count = (kind == jsu_pkg::KIND_DATA) ? '0 : count;
  assign dout.run_last = (rem == 2'd1);

endmodule

FILE: src/json_string_unescape_unit.sv
// The first result word of an input word is registered and valid in the cycle after it is accepted.
// Throughput: one input word per cycle while dout.ready is high; a \u escape that encodes to 2 or 3
// UTF-8 bytes holds the input while the bytes leave the result register.
// Reset (rst, synchronous) clears the escape state, error flag and byte count, and drops
// any result words still waiting.
module json_string_unescape_unit (
  input logic       clk,
  input logic       rst,
  jsu_in_if.sink    din,
  jsu_out_if.source dout
);

  jsu_pkg::run_t run;
  logic          accept;
  logic          can_take;

  assign din.ready = can_take;
  assign accept = din.valid && din.ready;

  // Escape decode and state
  jsu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (din.in_byte),
    .end_mark (din.end_mark),
    .run      (run)
  );

  // Result register and serializer
  jsu_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && run.n != 2'd0),
    .run      (run),
    .can_take (can_take),
    .dout     (dout)
  );

endmodule
